>>> rtl/core/pid_filtered_derivative_clamped_defines.svh
// Assertion macros shared by the controller core.
`ifndef PID_FILTERED_DERIVATIVE_CLAMPED_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_CLAMPED_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pfdc_pkg.sv
`default_nettype none

package pfdc_pkg;

  // Datapath widths: one 32 x 33 signed product, and an accumulator wide
  // enough to hold P + I - D exactly for any fraction width.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OPB_W  = 33;
  localparam int unsigned PROD_W = 65;
  localparam int unsigned ACC_W  = 68;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GAIN_PROP        = 3'd0;
  localparam cfg_idx_t CFG_GAIN_INT_HALF    = 3'd1;
  localparam cfg_idx_t CFG_GAIN_DERIV       = 3'd2;
  localparam cfg_idx_t CFG_FILTER_KEEP      = 3'd3;
  localparam cfg_idx_t CFG_FILTER_TAKE      = 3'd4;
  localparam cfg_idx_t CFG_OUT_UPPER        = 3'd5;
  localparam cfg_idx_t CFG_OUT_LOWER        = 3'd6;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_prop;
    logic signed [DATA_W-1:0] gain_int_half_period;
    logic signed [DATA_W-1:0] gain_deriv_per_period;
    logic signed [DATA_W-1:0] filter_keep;
    logic signed [DATA_W-1:0] filter_take;
    logic signed [DATA_W-1:0] out_upper;
    logic signed [DATA_W-1:0] out_lower;
  } cfg_regs_t;

  // Microprogram addresses.
  typedef logic [3:0] upc_t;
  localparam upc_t UPC_IDLE    = 4'd0;
  localparam upc_t UPC_ERROR   = 4'd1;
  localparam upc_t UPC_FKEEP   = 4'd2;
  localparam upc_t UPC_FTAKE   = 4'd3;
  localparam upc_t UPC_FILTER  = 4'd4;
  localparam upc_t UPC_INTEG   = 4'd5;
  localparam upc_t UPC_PLUS_I  = 4'd6;
  localparam upc_t UPC_MINUS_D = 4'd7;
  localparam upc_t UPC_DRIVE   = 4'd8;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN,
    COND_OUT
  } cond_e;

  typedef enum logic [2:0] {
    MA_KEEP,
    MA_TAKE,
    MA_KP,
    MA_KI,
    MA_KD
  } mula_sel_e;

  typedef enum logic [2:0] {
    MB_FILT,
    MB_MEAS,
    MB_ERR,
    MB_ESUM,
    MB_FDIFF
  } mulb_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_PROD,
    ACC_ADD_PROD,
    ACC_SUB_PROD,
    ACC_INTEG_PROD,
    ACC_ADD_INTEG
  } acc_op_e;

  typedef struct packed {
    cond_e     cond;
    upc_t      nxt;
    logic      ld_in;
    logic      wr_err;
    mula_sel_e mula;
    mulb_sel_e mulb;
    logic      mul_en;
    acc_op_e   acc_op;
    logic      wr_filt;
    logic      wr_integ;
    logic      wr_drive;
    logic      commit;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   go;
  } ctl_t;

  typedef struct packed {
    logic in_avail;
    logic out_free;
  } seq_stat_t;

  // The controller program: one control word per step.
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = '{cond: COND_ALWAYS, nxt: UPC_IDLE, ld_in: 1'b0, wr_err: 1'b0,
          mula: MA_KEEP, mulb: MB_FILT, mul_en: 1'b0, acc_op: ACC_HOLD,
          wr_filt: 1'b0, wr_integ: 1'b0, wr_drive: 1'b0, commit: 1'b0};
    unique case (pc)
      UPC_IDLE: begin
        w.cond  = COND_IN;
        w.nxt   = UPC_ERROR;
        w.ld_in = 1'b1;
      end
      UPC_ERROR: begin
        w.nxt    = UPC_FKEEP;
        w.wr_err = 1'b1;
        w.mula   = MA_KEEP;
        w.mulb   = MB_FILT;
        w.mul_en = 1'b1;
      end
      UPC_FKEEP: begin
        w.nxt    = UPC_FTAKE;
        w.mula   = MA_TAKE;
        w.mulb   = MB_MEAS;
        w.mul_en = 1'b1;
        w.acc_op = ACC_LOAD_PROD;
      end
      UPC_FTAKE: begin
        w.nxt    = UPC_FILTER;
        w.mula   = MA_KI;
        w.mulb   = MB_ESUM;
        w.mul_en = 1'b1;
        w.acc_op = ACC_ADD_PROD;
      end
      UPC_FILTER: begin
        w.nxt     = UPC_INTEG;
        w.wr_filt = 1'b1;
        w.mula    = MA_KP;
        w.mulb    = MB_ERR;
        w.mul_en  = 1'b1;
        w.acc_op  = ACC_INTEG_PROD;
      end
      UPC_INTEG: begin
        w.nxt      = UPC_PLUS_I;
        w.wr_integ = 1'b1;
        w.mula     = MA_KD;
        w.mulb     = MB_FDIFF;
        w.mul_en   = 1'b1;
        w.acc_op   = ACC_LOAD_PROD;
      end
      UPC_PLUS_I: begin
        w.nxt    = UPC_MINUS_D;
        w.acc_op = ACC_ADD_INTEG;
      end
      UPC_MINUS_D: begin
        w.nxt    = UPC_DRIVE;
        w.acc_op = ACC_SUB_PROD;
      end
      UPC_DRIVE: begin
        w.cond     = COND_OUT;
        w.nxt      = UPC_IDLE;
        w.wr_drive = 1'b1;
        w.commit   = 1'b1;
      end
      default: begin
        w.nxt = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/pfdc_sequencer.sv
`default_nettype none

module pfdc_sequencer (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  pfdc_pkg::seq_stat_t   stat_i,
  output pfdc_pkg::ctl_t        ctl_o
);
  import pfdc_pkg::*;

  upc_t   pc_q;
  upc_t   pc_d;
  uword_t uw;
  logic   go;

  assign uw = ucode_rom(pc_q);

  // A step whose condition is not met repeats; otherwise it jumps to nxt.
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN:     go = stat_i.in_avail;
      COND_OUT:    go = stat_i.out_free;
      default:     go = 1'b1;
    endcase
    pc_d = go ? uw.nxt : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o.uw = uw;
  assign ctl_o.go = go;

endmodule

`default_nettype wire

>>> rtl/core/pfdc_datapath.sv
`default_nettype none

module pfdc_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  pfdc_pkg::ctl_t             ctl_i,
  input  pfdc_pkg::cfg_regs_t        cfg_i,
  input  wire logic signed [31:0]    measured_i,
  input  wire logic signed [31:0]    setpoint_i,
  output logic signed [31:0]         drive_o
);
  import pfdc_pkg::*;

  // Saturate a wide value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat_acc(input logic [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_33(input logic [DATA_W:0] v);
    if (v[DATA_W] == v[DATA_W-1]) begin
      return v[DATA_W-1:0];
    end
    return v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  logic signed [DATA_W-1:0] meas_q, sp_q, err_q, prev_err_q;
  logic signed [DATA_W-1:0] integ_q, filt_q, filt_new_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DATA_W-1:0] op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] rnd;
  logic signed [ACC_W-1:0]  rnd_ext, integ_ext, upper_ext, lower_ext;
  logic        [DATA_W:0]   err_diff;
  logic        [OPB_W-1:0]  err_sum, filt_diff;
  logic signed [DATA_W-1:0] clamped;
  logic                     go;

  assign go = ctl_i.go;

  assign err_diff  = {sp_q[DATA_W-1], sp_q} - {meas_q[DATA_W-1], meas_q};
  assign err_sum   = {err_q[DATA_W-1], err_q} + {prev_err_q[DATA_W-1], prev_err_q};
  assign filt_diff = {filt_new_q[DATA_W-1], filt_new_q} - {filt_q[DATA_W-1], filt_q};

  always_comb begin
    unique case (ctl_i.uw.mula)
      MA_KEEP: op_a = cfg_i.filter_keep;
      MA_TAKE: op_a = cfg_i.filter_take;
      MA_KP:   op_a = cfg_i.gain_prop;
      MA_KI:   op_a = cfg_i.gain_int_half_period;
      MA_KD:   op_a = cfg_i.gain_deriv_per_period;
      default: op_a = '0;
    endcase
    unique case (ctl_i.uw.mulb)
      MB_FILT:  op_b = {filt_q[DATA_W-1], filt_q};
      MB_MEAS:  op_b = {meas_q[DATA_W-1], meas_q};
      MB_ERR:   op_b = {err_q[DATA_W-1], err_q};
      MB_ESUM:  op_b = err_sum;
      MB_FDIFF: op_b = filt_diff;
      default:  op_b = '0;
    endcase
  end

  // The single shared multiplier; its product is registered before use.
  assign prod_d = op_a * op_b;

  // Flooring shift of the exact product.
  assign rnd       = prod_q >>> FRAC_BITS;
  assign rnd_ext   = {{(ACC_W-PROD_W){rnd[PROD_W-1]}}, rnd};
  assign integ_ext = {{(ACC_W-DATA_W){integ_q[DATA_W-1]}}, integ_q};
  assign upper_ext = {{(ACC_W-DATA_W){cfg_i.out_upper[DATA_W-1]}}, cfg_i.out_upper};
  assign lower_ext = {{(ACC_W-DATA_W){cfg_i.out_lower[DATA_W-1]}}, cfg_i.out_lower};

  always_comb begin
    case (ctl_i.uw.acc_op)
      ACC_LOAD_PROD:  acc_d = rnd_ext;
      ACC_ADD_PROD:   acc_d = acc_q + rnd_ext;
      ACC_SUB_PROD:   acc_d = acc_q - rnd_ext;
      ACC_INTEG_PROD: acc_d = integ_ext + rnd_ext;
      ACC_ADD_INTEG:  acc_d = acc_q + integ_ext;
      default:        acc_d = acc_q;
    endcase
  end

  // Upper limit tested first: inverted limits give upper above it, else lower.
  always_comb begin
    if (acc_q > upper_ext) begin
      clamped = cfg_i.out_upper;
    end else if (acc_q < lower_ext) begin
      clamped = cfg_i.out_lower;
    end else begin
      clamped = acc_q[DATA_W-1:0];
    end
  end

  assign drive_o = clamped;

  always_ff @(posedge clk_i) begin
    if (go && ctl_i.uw.ld_in) begin
      meas_q <= measured_i;
      sp_q   <= setpoint_i;
    end
    if (go && ctl_i.uw.wr_err) begin
      err_q <= sat_33(err_diff);
    end
    if (go && ctl_i.uw.mul_en) begin
      prod_q <= prod_d;
    end
    if (go) begin
      acc_q <= acc_d;
    end
    if (go && ctl_i.uw.wr_filt) begin
      filt_new_q <= sat_acc(acc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      integ_q    <= '0;
      filt_q     <= '0;
    end else begin
      if (go && ctl_i.uw.wr_integ) begin
        integ_q <= clamped;
      end
      if (go && ctl_i.uw.commit) begin
        prev_err_q <= err_q;
        filt_q     <= filt_new_q;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pid_filtered_derivative_clamped.sv
// Channel  | Direction | Handshake                   | Payload
// ---------+-----------+-----------------------------+----------------------------
// in       | to core   | in_valid_i / in_stall_o     | measured_i, setpoint_i
// out      | from core | out_valid_o / out_stall_i   | drive_o
// cfg      | to core   | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_wdata_i
//
// One controller step runs from one input transaction to the next:
// eight microprogram steps, set by the five products that share one 32 x 33
// multiplier, plus the idle step that takes the transaction.
// The last step registers the result.
// Reset (rst_ni low, asynchronous) clears the controller state and loads the
// register reset values; no clearing pass is needed.
// A held result stalls only the last step; the next input waits until then.
`default_nettype none
`include "pid_filtered_derivative_clamped_defines.svh"

module pid_filtered_derivative_clamped #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // Input channel.
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [31:0]    measured_i,
  input  wire logic signed [31:0]    setpoint_i,
  // Output channel.
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic signed [31:0]         drive_o,
  // Configuration write channel.
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire pfdc_pkg::cfg_idx_t    cfg_index_i,
  input  wire logic [31:0]           cfg_wdata_i
);
  import pfdc_pkg::*;

  cfg_regs_t                cfg_q;
  ctl_t                     ctl;
  seq_stat_t                stat;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q;
  logic signed [DATA_W-1:0] drive_val;

  // The configuration port never pushes back; the user must write only while
  // the core is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop             <= '0;
      cfg_q.gain_int_half_period  <= '0;
      cfg_q.gain_deriv_per_period <= '0;
      cfg_q.filter_keep           <= '0;
      cfg_q.filter_take           <= 32'sd65536;
      cfg_q.out_upper             <= {1'b0, {(DATA_W-1){1'b1}}};
      cfg_q.out_lower             <= {1'b1, {(DATA_W-1){1'b0}}};
    end else if (cfg_valid_i && cfg_ready_o) begin
      // An index past the last register is dropped.
      unique case (cfg_index_i)
        CFG_GAIN_PROP:     cfg_q.gain_prop             <= cfg_wdata_i;
        CFG_GAIN_INT_HALF: cfg_q.gain_int_half_period  <= cfg_wdata_i;
        CFG_GAIN_DERIV:    cfg_q.gain_deriv_per_period <= cfg_wdata_i;
        CFG_FILTER_KEEP:   cfg_q.filter_keep           <= cfg_wdata_i;
        CFG_FILTER_TAKE:   cfg_q.filter_take           <= cfg_wdata_i;
        CFG_OUT_UPPER:     cfg_q.out_upper             <= cfg_wdata_i;
        CFG_OUT_LOWER:     cfg_q.out_lower             <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // The sequencer waits in the idle step for an input transaction and in the
  // last step for room in the output register.
  assign stat.in_avail = in_valid_i;
  assign stat.out_free = !out_valid_q || !out_stall_i;

  pfdc_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  pfdc_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .cfg_i      (cfg_q),
    .measured_i (measured_i),
    .setpoint_i (setpoint_i),
    .drive_o    (drive_val)
  );

  // Input is taken only in the idle step, which is the one that loads it.
  assign in_stall_o = !ctl.uw.ld_in;

  // Output register: the last step writes it when it is empty or being
  // drained in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.go && ctl.uw.wr_drive) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.go && ctl.uw.wr_drive) begin
      drive_q <= drive_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Once a step has started, no further input transaction is taken.
  `PFDC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken while a step was running")
  // A new result never overwrites one that is still waiting.
  `PFDC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, ctl.go && ctl.uw.wr_drive, !out_valid_q || !out_stall_i, "result overwritten while held")
  // After a result is written the program is back in its idle step.
  `PFDC_ASSERT_NEXT(a_idle_after_result, clk_i, rst_ni, ctl.go && ctl.uw.wr_drive, !in_stall_o, "program did not return to idle")

endmodule

`default_nettype wire

>>> dv/pid_filtered_derivative_clamped_test.sv
`timescale 1ns / 1ps

module pid_filtered_derivative_clamped_test;
  import pfdc_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int          LONG_HOLD   = 150;     // cycles of the long output hold-off
  localparam int          DRAIN_CYCLES = 12;     // margin after the last drive value returns
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_PHASES = 10;
  localparam int          STEPS_PER_PHASE = 110;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // Index 7 is outside the register map; a write there must change nothing.
  localparam cfg_idx_t CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [31:0] meas;
    logic signed [31:0] sp;
  } step_in_t;

  // Tracks the controller state and gains, works out the drive value for
  // every accepted sample, and compares the returned drive values in order.
  class drive_scoreboard;
    typedef logic signed [79:0] wide_t;
    localparam wide_t WORD_MAX = 80'sd2147483647;
    localparam wide_t WORD_MIN = -80'sd2147483648;

    cfg_regs_t          cfg;
    logic signed [31:0] last_err;
    logic signed [31:0] integ;
    logic signed [31:0] filt;
    logic signed [31:0] drive_q[$];
    int                 mismatches;
    int                 checked;
    int                 noted;

    function new();
      cfg = '{gain_prop: '0, gain_int_half_period: '0, gain_deriv_per_period: '0,
              filter_keep: '0, filter_take: Q_ONE, out_upper: Q_MAX, out_lower: Q_MIN};
      last_err   = '0;
      integ      = '0;
      filt       = '0;
      mismatches = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        CFG_GAIN_PROP:     cfg.gain_prop = val;
        CFG_GAIN_INT_HALF: cfg.gain_int_half_period = val;
        CFG_GAIN_DERIV:    cfg.gain_deriv_per_period = val;
        CFG_FILTER_KEEP:   cfg.filter_keep = val;
        CFG_FILTER_TAKE:   cfg.filter_take = val;
        CFG_OUT_UPPER:     cfg.out_upper = val;
        CFG_OUT_LOWER:     cfg.out_lower = val;
        default: ;
      endcase
    endfunction

    // Exact product, then an arithmetic shift, which rounds toward minus infinity.
    function wide_t scale(logic signed [31:0] g, wide_t x);
      wide_t gw;
      gw = g;
      return (gw * x) >>> FRAC_BITS;
    endfunction

    function wide_t sat_word(wide_t v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    // Upper bound is tested first, so inverted limits fall out naturally.
    function wide_t clamp_word(wide_t v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      wide_t              whi;
      wide_t              wlo;
      hi  = cfg.out_upper;
      lo  = cfg.out_lower;
      whi = hi;
      wlo = lo;
      if (v > whi) return whi;
      if (v < wlo) return wlo;
      return v;
    endfunction

    function void note_step(logic signed [31:0] meas, logic signed [31:0] sp);
      wide_t m, e, f, p, i, d, u;
      m = meas;
      e = sp;
      e = sat_word(e - m);
      f = sat_word(scale(cfg.filter_keep, filt) + scale(cfg.filter_take, m));
      p = scale(cfg.gain_prop, e);
      i = clamp_word(integ + scale(cfg.gain_int_half_period, e + last_err));
      d = scale(cfg.gain_deriv_per_period, f - filt);
      u = clamp_word(p + i - d);
      last_err = e[31:0];
      integ    = i[31:0];
      filt     = f[31:0];
      drive_q.push_back(u[31:0]);
      noted++;
    endfunction

    function void check_drive(logic signed [31:0] got);
      logic signed [31:0] want;
      if (drive_q.size() == 0) begin
        $display("%0t ns: drive %0d (0x%08h) arrived with nothing expected",
                 $time, got, got);
        mismatches++;
        return;
      end
      want = drive_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t ns: drive mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                 $time, want, want, got, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] measured_i;
  logic signed [31:0] setpoint_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] drive_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  cfg_idx_t           cfg_index_i;
  logic [31:0]        cfg_wdata_i;

  drive_scoreboard sb = new();

  step_in_t           plan[$];
  logic signed [31:0] target_sp = '0;
  bit                 calm = 1'b0;        // no idling on either side while set
  bit                 hold_long = 1'b0;   // asks the result sink for one long hold-off
  int                 long_holds = 0;
  int                 settings_run = 0;
  int                 cycle_count = 0;

  pid_filtered_derivative_clamped #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .measured_i  (measured_i),
    .setpoint_i  (setpoint_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 12 ns clock period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Guard against a hung handshake: the slowest correct run is well under a
  // tenth of this limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d drive values outstanding",
               $time, cycle_count, sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  // Every drive value taken by the sink is checked against the oldest
  // outstanding prediction. Sampling happens at the rising edge, before the
  // block's registers move, and all stimulus changes at the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_drive(drive_o);
    end
  end

  // Result sink. Before each transaction it draws a random hold-off (none
  // while calm is set) and keeps stall high that long once a result is waiting. On
  // request it draws the long hold-off instead, so the block keeps its
  // finished result, stops at its last step, and stalls the input side while
  // the sender keeps offering samples.
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        hold      = LONG_HOLD;
        hold_long = 1'b0;
        long_holds++;
      end else begin
        hold = calm ? 0 : $urandom_range(8, 0);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        while (!out_valid_o) @(negedge clk_i);
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Signed random value in [-half, half], in raw fixed-point counts.
  function automatic logic signed [31:0] q_span(input int unsigned half);
    logic signed [31:0] r;
    int                 h;
    r = $urandom_range(2 * half, 0);
    h = half;
    return r - h;
  endfunction

  function automatic logic signed [31:0] extreme_value();
    case ($urandom_range(3, 0))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // Gains are mostly small and realistic, with the full-scale values and
  // raw random words mixed in.
  function automatic logic signed [31:0] pick_gain();
    case ($urandom_range(7, 0))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return $urandom;
      default: return q_span(4 * Q_ONE);
    endcase
  endfunction

  function automatic cfg_regs_t random_cfg();
    cfg_regs_t          c;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic signed [31:0] keep;
    c.gain_prop             = pick_gain();
    c.gain_int_half_period  = pick_gain();
    c.gain_deriv_per_period = pick_gain();
    // Usually a proper low-pass filter whose weights add up to one.
    if ($urandom_range(3, 0) != 0) begin
      keep          = $urandom_range(Q_ONE, 0);
      c.filter_keep = keep;
      c.filter_take = Q_ONE - keep;
    end else begin
      c.filter_keep = pick_gain();
      c.filter_take = pick_gain();
    end
    case ($urandom_range(5, 0))
      0: begin
        hi = Q_MAX;
        lo = Q_MIN;
      end
      1: begin
        // Inverted: the upper limit sits below the lower one.
        lo = q_span(50 * Q_ONE);
        hi = lo - $urandom_range(20 * Q_ONE, 1);
      end
      2: begin
        hi = $urandom;
        lo = $urandom;
      end
      default: begin
        hi = $urandom_range(300 * Q_ONE, Q_ONE);
        lo = 0 - $urandom_range(300 * Q_ONE, Q_ONE);
      end
    endcase
    c.out_upper = hi;
    c.out_lower = lo;
    return c;
  endfunction

  // Most samples follow a slowly moving setpoint with a noisy measurement
  // around it, so the integrator and filter build up real history. The rest
  // are raw random words, full-scale extremes and tiny values.
  function automatic step_in_t random_step();
    step_in_t s;
    case ($urandom_range(9, 0))
      6, 7: begin
        s.meas = $urandom;
        s.sp   = $urandom;
      end
      8: begin
        s.meas = extreme_value();
        s.sp   = extreme_value();
      end
      9: begin
        s.meas = q_span(Q_ONE);
        s.sp   = q_span(Q_ONE);
      end
      default: begin
        if ($urandom_range(19, 0) == 0) target_sp = q_span(200 * Q_ONE);
        s.sp   = target_sp;
        s.meas = target_sp + q_span(5 * Q_ONE);
      end
    endcase
    return s;
  endfunction

  task automatic queue_step(input logic signed [31:0] meas, input logic signed [31:0] sp);
    plan.push_back('{meas: meas, sp: sp});
  endtask

  // Offers every queued sample in turn. Each one waits a random gap first;
  // without a gap valid simply stays high into the next transaction.
  // Called and returns at a falling edge.
  task automatic run_plan();
    step_in_t it;
    int       gap;
    while (plan.size() != 0) begin
      it  = plan.pop_front();
      gap = calm ? 0 : $urandom_range(8, 0);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      measured_i <= it.meas;
      setpoint_i <= it.sp;
      do @(posedge clk_i); while (in_stall_o);
      sb.note_step(it.meas, it.sp);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  // Waits until every predicted drive value has come back, then lets the
  // block run out its last step before the registers are touched.
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // One register write; valid stays high so writes can go back to back.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_cfg(input cfg_regs_t c, input bit poke_unmapped);
    write_reg(CFG_GAIN_PROP,     c.gain_prop);
    write_reg(CFG_GAIN_INT_HALF, c.gain_int_half_period);
    write_reg(CFG_GAIN_DERIV,    c.gain_deriv_per_period);
    write_reg(CFG_FILTER_KEEP,   c.filter_keep);
    write_reg(CFG_FILTER_TAKE,   c.filter_take);
    write_reg(CFG_OUT_UPPER,     c.out_upper);
    write_reg(CFG_OUT_LOWER,     c.out_lower);
    if (poke_unmapped) write_reg(CFG_UNMAPPED, $urandom);
    cfg_valid_i <= 1'b0;
    settings_run++;
  endtask

  initial begin : stimulus
    cfg_regs_t c;
    in_valid_i  = 1'b0;
    measured_i  = '0;
    setpoint_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GAIN_PROP;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: all gains zero and the filter passing the measurement
    // straight through, so the drive must stay at zero.
    queue_step(Q_MAX, Q_MIN);
    queue_step(10 * Q_ONE, -3 * Q_ONE);
    queue_step(Q_MIN, Q_MAX);
    run_plan();

    // Moderate gains with +/-100.0 limits: saturating error in both
    // directions, equal extremes and unit-step neighbors of zero.
    settle();
    c = '{gain_prop: Q_ONE, gain_int_half_period: Q_ONE >>> 2,
          gain_deriv_per_period: Q_ONE >>> 1, filter_keep: 3 * (Q_ONE >>> 2),
          filter_take: Q_ONE >>> 2, out_upper: 100 * Q_ONE, out_lower: -100 * Q_ONE};
    program_cfg(c, 1'b0);
    queue_step('0, '0);
    queue_step(Q_MIN, Q_MAX);
    queue_step(Q_MAX, Q_MIN);
    queue_step(Q_MAX, Q_MAX);
    queue_step(Q_MIN, Q_MIN);
    queue_step(-32'sd1, '0);
    queue_step('0, -32'sd1);
    queue_step(10 * Q_ONE, 12 * Q_ONE + (Q_ONE >>> 1));
    run_plan();

    // Inverted limits: the upper bound wins whenever it applies.
    settle();
    c = '{gain_prop: 2 * Q_ONE, gain_int_half_period: Q_ONE, gain_deriv_per_period: Q_ONE,
          filter_keep: '0, filter_take: Q_ONE, out_upper: -5 * Q_ONE, out_lower: 5 * Q_ONE};
    program_cfg(c, 1'b0);
    queue_step('0, 3 * Q_ONE);
    queue_step('0, -3 * Q_ONE);
    queue_step('0, 10 * Q_ONE);
    queue_step('0, -10 * Q_ONE);
    run_plan();

    // Full-scale positive gains and filter weights drive the filter into
    // saturation; a write to the unmapped index goes along with it.
    settle();
    c = '{gain_prop: Q_MAX, gain_int_half_period: Q_MAX, gain_deriv_per_period: Q_MAX,
          filter_keep: Q_MAX, filter_take: Q_MAX, out_upper: Q_MAX, out_lower: Q_MIN};
    program_cfg(c, 1'b1);
    queue_step(Q_MAX, '0);
    queue_step(Q_MAX, Q_MAX);
    queue_step(Q_MIN, Q_MAX);
    queue_step(Q_MIN, Q_MIN);
    queue_step(32'sd1, -32'sd1);
    run_plan();

    // Most negative everything, with the limits fully inverted.
    settle();
    c = '{gain_prop: Q_MIN, gain_int_half_period: Q_MIN, gain_deriv_per_period: Q_MIN,
          filter_keep: Q_MIN, filter_take: Q_MIN, out_upper: Q_MIN, out_lower: Q_MAX};
    program_cfg(c, 1'b0);
    queue_step(Q_MIN, Q_MAX);
    queue_step(Q_MAX, Q_MIN);
    queue_step('0, '0);
    queue_step(-32'sd1, -32'sd1);
    run_plan();

    // Random phases, each with fresh gains and limits. Controller state
    // carries over from phase to phase, as it would in a running loop.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      program_cfg(random_cfg(), ph % 3 == 0);
      calm = (ph % 4 == 1);
      if (ph == 2 || ph == 7) hold_long = 1'b1;
      for (int k = 0; k < STEPS_PER_PHASE; k++) plan.push_back(random_step());
      run_plan();
    end
    calm = 1'b0;
    settle();

    $display("Ran %0d controller steps under %0d register settings; %0d drive values checked.",
             sb.noted, settings_run, sb.checked);
    $display("Included saturating error and filter, inverted limits, an unmapped write and %0d long output holds.",
             long_holds);
    if (sb.pending() != 0) begin
      $display("%0t ns: %0d expected drive values never arrived", $time, sb.pending());
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
